// ===== src/vpfc_pkg.sv =====
// vpfc_pkg: shared types, codes and constants of the video-memory page engine
// used by the channel interfaces, the controller and the top level
package vpfc_pkg;

  localparam int unsigned VRAM_WORDS_DEF = 262144;
  localparam int unsigned PAGE_WORDS_DEF = 512;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned WADDR_W  = 18;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned OFF_W    = 18;
  localparam int unsigned PAGE_SEL_W = 11;
  localparam int unsigned PAGE_SHIFT = 7;
  localparam int unsigned SEL_W    = 3;

  localparam logic [DATA_W-1:0] FULL_MASK = 32'hFFFF_FFFF;

  // page access decode on index bits 15..13
  localparam logic [SEL_W-1:0] SEL_COPY  = 3'd0;
  localparam logic [SEL_W-1:0] SEL_COLOR = 3'd1;
  localparam logic [SEL_W-1:0] SEL_FILL  = 3'd2;

  typedef enum logic [OP_W-1:0] {
    OP_PAGE    = 2'd0,
    OP_SRC     = 2'd1,
    OP_HOST_RD = 2'd2,
    OP_HOST_WR = 2'd3
  } op_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_IGNORE = 3'd0,
    ACT_FILL   = 3'd1,
    ACT_COPY   = 3'd2,
    ACT_COLOR  = 3'd3,
    ACT_SOURCE = 3'd4,
    ACT_HOST   = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_SRC,
    ST_RD_DST,
    ST_WRITE,
    ST_HOST_RD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              valid;
    action_e           action;
    logic [DATA_W-1:0] read_data;
  } res_t;

  function automatic logic [OFF_W-1:0] page_base(input logic [INDEX_W-1:0] index);
    return {index[PAGE_SEL_W-1:0], {PAGE_SHIFT{1'b0}}};
  endfunction

endpackage

// ===== src/vpfc_if.sv =====
// vpfc_in_if / vpfc_out_if: valid-ready channels for command and result words
// depends on vpfc_pkg for field widths
interface vpfc_in_if
  import vpfc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [INDEX_W-1:0] index;
  logic [DATA_W-1:0]  mask;
  logic [WADDR_W-1:0] word_address;
  logic [DATA_W-1:0]  word_data;

  modport source (output valid, opcode, index, mask, word_address, word_data, input ready);
  modport sink   (input valid, opcode, index, mask, word_address, word_data, output ready);
endinterface

interface vpfc_out_if
  import vpfc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, action, read_data, input ready);
  modport sink   (input valid, action, read_data, output ready);
endinterface

// ===== src/vpfc_ram.sv =====
// vpfc_ram: generic single-port synchronous RAM, registered read
// no dependencies
module vpfc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vpfc_ctrl.sv =====
// vpfc_ctrl: command decode, page walk sequencer and read-modify-write merge
// depends on vpfc_pkg and vpfc_in_if; drives the single port of vpfc_ram
module vpfc_ctrl
  import vpfc_pkg::*;
#(
  parameter int unsigned VRAM_WORDS = VRAM_WORDS_DEF,
  parameter int unsigned PAGE_WORDS = PAGE_WORDS_DEF,
  localparam int unsigned AW = $clog2(VRAM_WORDS),
  localparam int unsigned CW = $clog2(PAGE_WORDS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vpfc_in_if.sink           in_i,
  output res_t              res_o,
  input  logic              res_ready_i,
  output logic              mem_en_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_addr_o,
  output logic [DATA_W-1:0] mem_wdata_o,
  input  logic [DATA_W-1:0] mem_rdata_i
);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0] color_q, color_d;
  logic [OFF_W-1:0]  src_off_q, src_off_d;
  // working page base: destination of a copy, target of a fill
  logic [OFF_W-1:0]  base_q, base_d;
  logic [DATA_W-1:0] mask_q, mask_d;
  logic              full_q, full_d;
  logic              copy_q, copy_d;
  logic [DATA_W-1:0] src_q, src_d;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  action_e           act_q, act_d;

  logic [AW-1:0]     src_addr, dst_addr, host_addr;
  logic [DATA_W-1:0] new_val, merged;
  logic [SEL_W-1:0]  sel;
  logic              last;

  assign src_addr  = AW'(src_off_q) + AW'(cnt_q);
  assign dst_addr  = AW'(base_q) + AW'(cnt_q);
  assign host_addr = AW'(in_i.word_address);
  assign sel       = in_i.index[INDEX_W-1 -: SEL_W];
  assign last      = (cnt_q == CW'(PAGE_WORDS - 1));

  // mask bit set keeps the old bit, clear takes the new one; an all-ones mask writes the new word whole
  assign new_val = copy_q ? (full_q ? mem_rdata_i : src_q) : color_q;
  assign merged  = full_q ? new_val : (((mem_rdata_i ^ new_val) & mask_q) ^ new_val);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    color_d     = color_q;
    src_off_d   = src_off_q;
    base_d      = base_q;
    mask_d      = mask_q;
    full_d      = full_q;
    copy_d      = copy_q;
    src_d       = src_q;
    rdata_d     = rdata_q;
    act_d       = act_q;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = dst_addr;
    mem_wdata_o = merged;
    in_i.ready  = 1'b0;
    res_o.valid     = 1'b0;
    res_o.action    = act_q;
    res_o.read_data = rdata_q;

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          mask_d  = in_i.mask;
          full_d  = (in_i.mask == FULL_MASK);
          base_d  = page_base(in_i.index);
          rdata_d = '0;
          cnt_d   = '0;
          act_d   = ACT_IGNORE;
          copy_d  = 1'b0;
          state_d = ST_DONE;
          case (op_e'(in_i.opcode))
            OP_PAGE: begin
              case (sel)
                SEL_FILL: begin
                  act_d   = ACT_FILL;
                  state_d = (in_i.mask == FULL_MASK) ? ST_WRITE : ST_RD_DST;
                end
                SEL_COPY: begin
                  act_d   = ACT_COPY;
                  copy_d  = 1'b1;
                  state_d = ST_RD_SRC;
                end
                SEL_COLOR: begin
                  act_d   = ACT_COLOR;
                  color_d = in_i.mask;
                end
                default: ;
              endcase
            end
            OP_SRC: begin
              act_d     = ACT_SOURCE;
              src_off_d = page_base(in_i.index);
            end
            OP_HOST_RD: begin
              act_d      = ACT_HOST;
              mem_en_o   = 1'b1;
              mem_addr_o = host_addr;
              state_d    = ST_HOST_RD;
            end
            OP_HOST_WR: begin
              act_d       = ACT_HOST;
              mem_en_o    = 1'b1;
              mem_we_o    = 1'b1;
              mem_addr_o  = host_addr;
              mem_wdata_o = in_i.word_data;
            end
            default: ;
          endcase
        end
      end
      ST_RD_SRC: begin
        mem_en_o   = 1'b1;
        mem_addr_o = src_addr;
        state_d    = full_q ? ST_WRITE : ST_RD_DST;
      end
      ST_RD_DST: begin
        mem_en_o   = 1'b1;
        mem_addr_o = dst_addr;
        if (copy_q) begin
          src_d = mem_rdata_i;
        end
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        mem_en_o = 1'b1;
        mem_we_o = 1'b1;
        if (last) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = copy_q ? ST_RD_SRC : (full_q ? ST_WRITE : ST_RD_DST);
        end
      end
      ST_HOST_RD: begin
        rdata_d = mem_rdata_i;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      color_q   <= '0;
      src_off_q <= '0;
      act_q     <= ACT_IGNORE;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      color_q   <= color_d;
      src_off_q <= src_off_d;
      act_q     <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    mask_q  <= mask_d;
    full_q  <= full_d;
    copy_q  <= copy_d;
    src_q   <= src_d;
    rdata_q <= rdata_d;
  end

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> cnt_q == '0)
    else $error("page counter not cleared at idle");

  a_masked_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE && !full_q |-> $past(state_q) == ST_RD_DST)
    else $error("masked write without destination read");

  a_host_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOST_RD |-> $past(mem_en_o && !mem_we_o))
    else $error("host read data taken without a read");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_ready_i |=> res_o.valid && $stable(res_o.action)
      && $stable(res_o.read_data))
    else $error("pending result changed");

endmodule

// ===== src/vram_page_fill_copy_engine.sv =====
// Video-memory page fill and copy engine. One command word is taken at a time; it yields
// one result word. Colour set, source set and host write go from idle to the result; a host
// read passes a read state first. A fill walks PAGE_WORDS words: one word per cycle with an
// all-ones mask, a read and a write per word otherwise. A copy takes a source read and a
// write per word with an all-ones mask, and a source read, a destination read and a write
// otherwise, as the video RAM has a single port. A finished result sits in an output
// register so the next command is taken while it waits. The RAM has no reset.
module vram_page_fill_copy_engine
  import vpfc_pkg::*;
#(
  parameter int unsigned VRAM_WORDS = VRAM_WORDS_DEF,
  parameter int unsigned PAGE_WORDS = PAGE_WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vpfc_in_if.sink    in_i,
  vpfc_out_if.source out_o
);

  localparam int unsigned AW = $clog2(VRAM_WORDS);

  res_t              res;
  logic              res_ready;
  logic              mem_en, mem_we;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  logic              out_valid_q, out_valid_d;
  action_e           out_act_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_load;

  vpfc_ctrl #(
    .VRAM_WORDS (VRAM_WORDS),
    .PAGE_WORDS (PAGE_WORDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_en_o    (mem_en),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  vpfc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VRAM_WORDS)
  ) u_vram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // output word register
  assign res_ready   = !out_valid_q || out_o.ready;
  assign out_load    = res.valid && res_ready;
  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_act_q  <= res.action;
      out_data_q <= res.read_data;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.action    = out_act_q;
  assign out_o.read_data = out_data_q;

endmodule

// ===== tb/tb_vram_page_fill_copy_engine.sv =====
`timescale 1ns / 1ps
// tb_vram_page_fill_copy_engine: self-checking bench for the video-memory page engine,
// with a clocked command driver, a result monitor and a word-level memory image as predictor
// depends on vpfc_pkg, the vpfc_in_if / vpfc_out_if channels and vram_page_fill_copy_engine
module tb_vram_page_fill_copy_engine;
  import vpfc_pkg::*;

  localparam int VRAM_WORDS  = VRAM_WORDS_DEF;
  localparam int PAGE_WORDS  = PAGE_WORDS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    op_e                opcode;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  mask;
    logic [WADDR_W-1:0] word_address;
    logic [DATA_W-1:0]  word_data;
  } page_cmd_t;

  typedef struct packed {
    action_e           action;
    logic [DATA_W-1:0] read_data;
  } page_result_t;

  logic clk_i;
  logic rst_ni;

  vpfc_in_if  cmd_if ();
  vpfc_out_if res_if ();

  vram_page_fill_copy_engine dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // predicted engine state
  logic [DATA_W-1:0] vram_image [VRAM_WORDS];
  logic [DATA_W-1:0] color_reg = '0;
  logic [OFF_W-1:0]  src_base  = '0;
  logic [OFF_W-1:0]  dst_base  = '0;

  // stimulus planning state, so that no unwritten word is ever read
  bit                    vram_written [VRAM_WORDS];
  logic [PAGE_SEL_W-1:0] plan_src_page = '0;

  page_cmd_t    cmd_backlog[$];
  page_result_t awaited_results[$];
  page_cmd_t    cur_cmd;
  page_result_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go = 1'b0;
  int hold_left;
  int idle_cycles;
  int mismatches = 0;

  function automatic page_result_t apply_cmd(page_cmd_t c);
    page_result_t     res;
    logic [OFF_W-1:0] base;
    logic [OFF_W-1:0] d;
    logic [OFF_W-1:0] s;
    logic [DATA_W-1:0] src_word;
    int i;
    res.action    = ACT_IGNORE;
    res.read_data = '0;
    base = OFF_W'(c.index[PAGE_SEL_W-1:0]) << PAGE_SHIFT;
    case (c.opcode)
      OP_PAGE: begin
        case (c.index[INDEX_W-1:INDEX_W-SEL_W])
          SEL_FILL: begin
            for (i = 0; i < PAGE_WORDS; i++) begin
              d = OFF_W'(base + i);
              if (c.mask == FULL_MASK) vram_image[d] = color_reg;
              else vram_image[d] = ((vram_image[d] ^ color_reg) & c.mask) ^ color_reg;
            end
            res.action = ACT_FILL;
          end
          SEL_COPY: begin
            dst_base = base;
            // word by word in rising order, so overlapping pages see fresh words
            for (i = 0; i < PAGE_WORDS; i++) begin
              d = OFF_W'(dst_base + i);
              s = OFF_W'(src_base + i);
              src_word = vram_image[s];
              if (c.mask == FULL_MASK) vram_image[d] = src_word;
              else vram_image[d] = ((vram_image[d] ^ src_word) & c.mask) ^ src_word;
            end
            res.action = ACT_COPY;
          end
          SEL_COLOR: begin
            color_reg  = c.mask;
            res.action = ACT_COLOR;
          end
          default: ;
        endcase
      end
      OP_SRC: begin
        src_base   = base;
        res.action = ACT_SOURCE;
      end
      OP_HOST_RD: begin
        res.read_data = vram_image[c.word_address];
        res.action    = ACT_HOST;
      end
      OP_HOST_WR: begin
        vram_image[c.word_address] = c.word_data;
        res.action                 = ACT_HOST;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic page_cmd_t mk_cmd(op_e op, logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] m,
                                       logic [WADDR_W-1:0] a, logic [DATA_W-1:0] dat);
    page_cmd_t c;
    c.opcode       = op;
    c.index        = idx;
    c.mask         = m;
    c.word_address = a;
    c.word_data    = dat;
    return c;
  endfunction

  function automatic bit page_is_written(logic [PAGE_SEL_W-1:0] pg);
    logic [OFF_W-1:0] a;
    int i;
    for (i = 0; i < PAGE_WORDS; i++) begin
      a = OFF_W'((OFF_W'(pg) << PAGE_SHIFT) + i);
      if (!vram_written[a]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic queue_cmd(page_cmd_t c);
    logic [OFF_W-1:0] a;
    logic [SEL_W-1:0] sel;
    int i;
    sel = c.index[INDEX_W-1:INDEX_W-SEL_W];
    if (c.opcode == OP_PAGE && (sel == SEL_FILL || sel == SEL_COPY)) begin
      for (i = 0; i < PAGE_WORDS; i++) begin
        a = OFF_W'((OFF_W'(c.index[PAGE_SEL_W-1:0]) << PAGE_SHIFT) + i);
        vram_written[a] = 1'b1;
      end
    end else if (c.opcode == OP_SRC) begin
      plan_src_page = c.index[PAGE_SEL_W-1:0];
    end else if (c.opcode == OP_HOST_WR) begin
      vram_written[c.word_address] = 1'b1;
    end
    cmd_backlog.push_back(c);
  endtask

  // unmasked fill, which reads nothing, so that later reads of the page are defined
  task automatic prime_page(logic [PAGE_SEL_W-1:0] pg);
    queue_cmd(mk_cmd(OP_PAGE, {SEL_FILL, 2'($urandom), pg}, FULL_MASK, WADDR_W'($urandom),
                     $urandom));
  endtask

  function automatic logic [PAGE_SEL_W-1:0] pick_page();
    int r;
    r = $urandom_range(99);
    if (r < 60) return PAGE_SEL_W'($urandom_range(31));
    if (r < 70) return PAGE_SEL_W'($urandom_range(2047, 2040));
    return PAGE_SEL_W'($urandom_range(2047));
  endfunction

  function automatic logic [DATA_W-1:0] pick_mask();
    int r;
    r = $urandom_range(99);
    if (r < 25) return FULL_MASK;
    if (r < 35) return '0;
    if (r < 45) return FULL_MASK ^ (32'd1 << $urandom_range(31));
    return $urandom;
  endfunction

  function automatic logic [WADDR_W-1:0] pick_addr(logic [PAGE_SEL_W-1:0] pg);
    if ($urandom_range(99) < 60)
      return WADDR_W'((OFF_W'(pg) << PAGE_SHIFT) + $urandom_range(PAGE_WORDS - 1));
    return WADDR_W'($urandom);
  endfunction

  task automatic gen_random();
    int r;
    logic [PAGE_SEL_W-1:0] pg;
    logic [DATA_W-1:0]     m;
    logic [WADDR_W-1:0]    a;
    r  = $urandom_range(99);
    pg = pick_page();
    m  = pick_mask();
    if (r < 12) begin
      if (m != FULL_MASK && !page_is_written(pg)) prime_page(pg);
      queue_cmd(mk_cmd(OP_PAGE, {SEL_FILL, 2'($urandom), pg}, m, WADDR_W'($urandom),
                       $urandom));
    end else if (r < 24) begin
      if (!page_is_written(plan_src_page)) prime_page(plan_src_page);
      if (m != FULL_MASK && !page_is_written(pg)) prime_page(pg);
      queue_cmd(mk_cmd(OP_PAGE, {SEL_COPY, 2'($urandom), pg}, m, WADDR_W'($urandom),
                       $urandom));
    end else if (r < 30) begin
      queue_cmd(mk_cmd(OP_PAGE, {SEL_COLOR, 13'($urandom)}, m, WADDR_W'($urandom),
                       $urandom));
    end else if (r < 35) begin
      queue_cmd(mk_cmd(OP_PAGE, 16'($urandom_range(16'hFFFF, 16'h6000)), m,
                       WADDR_W'($urandom), $urandom));
    end else if (r < 50) begin
      queue_cmd(mk_cmd(OP_SRC, {5'($urandom), pg}, m, WADDR_W'($urandom), $urandom));
    end else if (r < 75) begin
      a = pick_addr(pg);
      if (!vram_written[a]) queue_cmd(mk_cmd(OP_HOST_WR, 16'($urandom), m, a, $urandom));
      queue_cmd(mk_cmd(OP_HOST_RD, 16'($urandom), m, a, $urandom));
    end else begin
      queue_cmd(mk_cmd(OP_HOST_WR, 16'($urandom), m, pick_addr(pg), $urandom));
    end
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || cmd_if.valid || awaited_results.size() != 0)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid        <= 1'b0;
      cmd_if.opcode       <= OP_PAGE;
      cmd_if.index        <= '0;
      cmd_if.mask         <= '0;
      cmd_if.word_address <= '0;
      cmd_if.word_data    <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) awaited_results.push_back(apply_cmd(cur_cmd));
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_backlog.pop_front();
          cmd_if.valid        <= 1'b1;
          cmd_if.opcode       <= cur_cmd.opcode;
          cmd_if.index        <= cur_cmd.index;
          cmd_if.mask         <= cur_cmd.mask;
          cmd_if.word_address <= cur_cmd.word_address;
          cmd_if.word_data    <= cur_cmd.word_data;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result word: action %0d read_data %h", res_if.action,
                 res_if.read_data);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (res_if.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, res_if.action);
            mismatches++;
          end
          if (res_if.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, res_if.read_data);
            mismatches++;
          end
        end
      end
      // long hold-off so the engine backs up and stalls its command side
      if (hold_go) begin
        hold_left    <= HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 47;
    // host words at the address extremes
    queue_cmd(mk_cmd(OP_HOST_WR, 16'h0000, 32'h0, 18'h00000, 32'hFFFF_FFFF));
    queue_cmd(mk_cmd(OP_HOST_WR, 16'hFFFF, FULL_MASK, 18'h3FFFF, 32'h0));
    queue_cmd(mk_cmd(OP_HOST_RD, 16'h0000, 32'h0, 18'h3FFFF, 32'hFFFF_FFFF));
    queue_cmd(mk_cmd(OP_HOST_RD, 16'hFFFF, FULL_MASK, 18'h00000, 32'h0));
    // colour set, unmasked fills of page zero and of the page that wraps round
    queue_cmd(mk_cmd(OP_PAGE, 16'h2000, FULL_MASK, 18'h0, 32'h0));
    queue_cmd(mk_cmd(OP_PAGE, 16'h4000, FULL_MASK, 18'h0, 32'h0));
    queue_cmd(mk_cmd(OP_PAGE, 16'h3FFF, 32'h0, 18'h3FFFF, 32'h0));
    queue_cmd(mk_cmd(OP_PAGE, 16'h47FF, FULL_MASK, 18'h0, 32'h0));
    queue_cmd(mk_cmd(OP_PAGE, 16'h2000, 32'hA5A5_5A5A, 18'h0, 32'h0));
    // masked fills keep old bits where the mask is set
    queue_cmd(mk_cmd(OP_PAGE, 16'h4000, 32'h0000_FFFF, 18'h0, 32'h0));
    queue_cmd(mk_cmd(OP_PAGE, 16'h5FFF, 32'h0, 18'h0, 32'h0));
    // copies, including overlapping pages and a wrapping destination
    queue_cmd(mk_cmd(OP_SRC, 16'hFFFF, 32'h0, 18'h0, 32'h0));
    queue_cmd(mk_cmd(OP_PAGE, 16'h0004, FULL_MASK, 18'h0, 32'h0));
    queue_cmd(mk_cmd(OP_SRC, 16'h0000, FULL_MASK, 18'h3FFFF, 32'hFFFF_FFFF));
    queue_cmd(mk_cmd(OP_PAGE, 16'h0002, 32'hF0F0_F0F0, 18'h0, 32'h0));
    queue_cmd(mk_cmd(OP_PAGE, 16'h1FFF, 32'h0, 18'h0, 32'h0));
    queue_cmd(mk_cmd(OP_SRC, 16'h0004, 32'h0, 18'h0, 32'h0));
    queue_cmd(mk_cmd(OP_PAGE, 16'h0000, FULL_MASK, 18'h0, 32'h0));
    // index above the decoded ranges does nothing
    queue_cmd(mk_cmd(OP_PAGE, 16'h6000, 32'h1234_5678, 18'h0, 32'h0));
    queue_cmd(mk_cmd(OP_PAGE, 16'hFFFF, FULL_MASK, 18'h3FFFF, 32'hFFFF_FFFF));
    queue_cmd(mk_cmd(OP_HOST_RD, 16'h0000, 32'h0, 18'd300, 32'h0));
    queue_cmd(mk_cmd(OP_HOST_WR, 16'h0000, 32'h0, 18'h2AAAA, 32'h5555_AAAA));
    queue_cmd(mk_cmd(OP_HOST_RD, 16'h0000, 32'h0, 18'h2AAAA, 32'h0));
    queue_cmd(mk_cmd(OP_HOST_RD, 16'h0000, 32'h0, 18'h3FFFF, 32'h0));
    for (i = 0; i < 150; i++) gen_random();
    drain();

    send_idle_pct = 47;
    recv_idle_pct = 32;
    for (i = 0; i < 155; i++) gen_random();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    // a burst of quick words piles up behind the held-off result
    for (i = 0; i < 25; i++) begin
      case (i % 3)
        0: queue_cmd(mk_cmd(OP_HOST_WR, 16'($urandom), $urandom, WADDR_W'($urandom),
                            $urandom));
        1: queue_cmd(mk_cmd(OP_PAGE, {SEL_COLOR, 13'($urandom)}, $urandom,
                            WADDR_W'($urandom), $urandom));
        default: queue_cmd(mk_cmd(OP_SRC, {5'($urandom), pick_page()}, $urandom,
                                  WADDR_W'($urandom), $urandom));
      endcase
    end
    @(negedge clk_i);
    hold_go = 1'b0;
    for (i = 0; i < 135; i++) gen_random();
    drain();

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
